[hw/rtl/ihex_pkg.sv]
// Shared constants, handshake structs and lookup functions for the HEX record loader.
// No dependencies; used by ihex_ctrl, ihex_dp and intel_hex_record_loader.
package ihex_pkg;

    localparam int STORE_WORDS = 1024;
    localparam int LINE_BYTES  = 256;
    localparam int STORE_AW    = $clog2(STORE_WORDS);
    localparam int LINE_PAIRS  = (LINE_BYTES + 1) / 2;  // even/odd byte banks
    localparam int COPY_PAIRS  = LINE_BYTES / 2;        // pairs with both bytes kept
    localparam int PAIR_AW     = $clog2(LINE_PAIRS);

    localparam logic [15:0] ERASED_WORD = 16'h3FFF;
    localparam logic [9:0]  COUNT_MAX   = 10'd1023;
    localparam logic [9:0]  END_LEN     = 10'd11;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // command codes
    localparam logic [1:0] CMD_CHAR    = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_VERDICT = 2'd2;

    // line events
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_ACCEPTED = 2'd1;
    localparam logic [1:0] EV_REJECTED = 2'd2;
    localparam logic [1:0] EV_END      = 2'd3;

    // file verdicts
    localparam logic [1:0] VERDICT_PENDING = 2'd0;
    localparam logic [1:0] VERDICT_VALID   = 2'd1;
    localparam logic [1:0] VERDICT_INVALID = 2'd2;

    typedef struct packed {
        logic load_item;
        logic clear_step;
        logic exec;
        logic copy_step;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
        logic need_copy;
        logic copy_last;
    } dp_sts_t;

    // non-hex characters count as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

    // text of the end record ":00000001FF"
    function automatic logic [7:0] end_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:       ch = CH_COLON;
            4'd8:       ch = 8'h31;
            4'd9,
            4'd10:      ch = 8'h46;
            default:    ch = 8'h30;
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/ihex_ctrl.sv]
// Sequencer for the HEX record loader: store clear, item execute, word copy.
// Depends on ihex_pkg; drives ihex_dp through ctl_cmd_t, reads dp_sts_t.
module ihex_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output ihex_pkg::ctl_cmd_t ctl,
    input  ihex_pkg::dp_sts_t  sts
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_COPY  = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // commit only when the result can go straight out
                if (sts.out_free)
                begin
                    ctl.exec   = 1'b1;
                    state_next = sts.need_copy ? ST_COPY : ST_IDLE;
                end
            end
            ST_COPY:
            begin
                ctl.copy_step = 1'b1;
                if (sts.copy_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;  // last word write lands here
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

[hw/rtl/ihex_dp.sv]
// Datapath of the HEX record loader: line parser, line byte banks, word store, result register.
// Depends on ihex_pkg; sequenced by ihex_ctrl.
module ihex_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ihex_pkg::ctl_cmd_t ctl,
    output ihex_pkg::dp_sts_t  sts,
    input  logic [1:0]         cmd,
    input  logic [7:0]         char_code,
    input  logic [9:0]         read_address,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [1:0]         line_event,
    output logic [1:0]         file_verdict,
    output logic [15:0]        read_word,
    output logic               error_seen
);

    localparam int STORE_AW = ihex_pkg::STORE_AW;
    localparam int PAIR_AW  = ihex_pkg::PAIR_AW;

    // item registers
    logic [1:0]  cmd_reg;
    logic [7:0]  char_reg;
    logic [9:0]  raddr_reg;
    logic        in_range_reg;

    // line state
    logic [9:0]  count_reg,   count_next;
    logic [3:0]  nibble_reg,  nibble_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [7:0]  len_reg,     len_next;
    logic [15:0] addr_reg,    addr_next;
    logic [7:0]  type_reg,    type_next;
    logic        colon_ok_reg, colon_ok_next;
    logic        end_miss_reg, end_miss_next;
    logic        err_reg,      err_next;
    logic        end_seen_reg, end_seen_next;

    // copy engine
    logic [6:0]          copy_n_reg;
    logic [14:0]         copy_base_reg;
    logic [6:0]          copy_k_reg;
    logic                wr_v_reg;
    logic                wr_ok_reg;
    logic [STORE_AW-1:0] wr_addr_reg;
    logic [STORE_AW-1:0] clr_idx_reg;
    logic [16:0]         copy_sum;

    // memories
    logic [15:0] word_mem [ihex_pkg::STORE_WORDS];
    logic [7:0]  even_mem [ihex_pkg::LINE_PAIRS];
    logic [7:0]  odd_mem  [ihex_pkg::LINE_PAIRS];
    logic [15:0] word_q;
    logic [7:0]  lo_q;
    logic [7:0]  hi_q;
    logic [STORE_AW-1:0] rd_idx;

    // result register
    logic        out_valid_reg;
    logic [1:0]  ev_out_reg;
    logic [1:0]  verdict_out_reg;
    logic [15:0] word_out_reg;
    logic        err_out_reg;

    logic        eol_char, is_end, take;
    logic [9:0]  len_chars;
    logic [1:0]  ev;
    logic [7:0]  byte_val;
    logic [8:0]  byte_idx;
    logic [8:0]  data_idx;
    logic        lb_we;
    logic [1:0]  verdict;
    logic [15:0] word_res;

    assign eol_char  = (char_reg == ihex_pkg::CH_CR) || (char_reg == ihex_pkg::CH_LF);
    assign is_end    = ((cmd_reg == ihex_pkg::CMD_CHAR) && eol_char)
                     || (cmd_reg == ihex_pkg::CMD_VERDICT);
    assign take      = (cmd_reg == ihex_pkg::CMD_CHAR) && !eol_char;
    assign len_chars = ihex_pkg::END_LEN + {1'b0, len_reg, 1'b0};

    always_comb
    begin
        if ((count_reg == 10'd0) || err_reg)
        begin
            ev = ihex_pkg::EV_NONE;
        end
        else if (!end_miss_reg && (count_reg == ihex_pkg::END_LEN))
        begin
            ev = ihex_pkg::EV_END;
        end
        else if (colon_ok_reg && (count_reg == len_chars) && (sum_reg == 8'd0))
        begin
            ev = ihex_pkg::EV_ACCEPTED;
        end
        else
        begin
            ev = ihex_pkg::EV_REJECTED;
        end
    end

    assign byte_val = {nibble_reg, ihex_pkg::hex_value(char_reg)};
    assign byte_idx = count_reg[9:1] - 9'd1;
    assign data_idx = byte_idx - 9'd4;

    // line parser next state
    always_comb
    begin
        count_next    = count_reg;
        nibble_next   = nibble_reg;
        sum_next      = sum_reg;
        len_next      = len_reg;
        addr_next     = addr_reg;
        type_next     = type_reg;
        colon_ok_next = colon_ok_reg;
        end_miss_next = end_miss_reg;
        err_next      = err_reg;
        end_seen_next = end_seen_reg;
        lb_we         = 1'b0;
        if (ctl.exec && take)
        begin
            if (count_reg == ihex_pkg::COUNT_MAX)
            begin
                end_miss_next = 1'b1;  // saturated, line is lost
            end
            else
            begin
                if ((count_reg >= ihex_pkg::END_LEN)
                    || (char_reg != ihex_pkg::end_char(count_reg[3:0])))
                begin
                    end_miss_next = 1'b1;
                end
                if (count_reg == 10'd0)
                begin
                    if (char_reg != ihex_pkg::CH_COLON)
                    begin
                        colon_ok_next = 1'b0;
                    end
                end
                else if (count_reg[0])
                begin
                    nibble_next = ihex_pkg::hex_value(char_reg);
                end
                else
                begin
                    sum_next = sum_reg + byte_val;
                    case (byte_idx)
                        9'd0:    len_next  = byte_val;
                        9'd1:    addr_next = {byte_val, addr_reg[7:0]};
                        9'd2:    addr_next = {addr_reg[15:8], byte_val};
                        9'd3:    type_next = byte_val;
                        default: lb_we     = (data_idx < 9'(ihex_pkg::LINE_BYTES));
                    endcase
                end
                count_next = count_reg + 10'd1;
            end
        end
        else if (ctl.exec && is_end)
        begin
            count_next    = 10'd0;
            nibble_next   = 4'd0;
            sum_next      = 8'd0;
            len_next      = 8'd0;
            addr_next     = 16'd0;
            type_next     = 8'd0;
            colon_ok_next = 1'b1;
            end_miss_next = 1'b0;
            err_next      = err_reg | (ev == ihex_pkg::EV_REJECTED);
            end_seen_next = end_seen_reg | (ev == ihex_pkg::EV_END);
        end
    end

    assign verdict  = (cmd_reg != ihex_pkg::CMD_VERDICT) ? ihex_pkg::VERDICT_PENDING
                    : (!err_next && end_seen_next) ? ihex_pkg::VERDICT_VALID
                    : ihex_pkg::VERDICT_INVALID;
    assign word_res = ((cmd_reg == ihex_pkg::CMD_READ) && in_range_reg) ? word_q : 16'd0;

    assign copy_sum = {2'b00, copy_base_reg} + {10'd0, copy_k_reg};
    assign rd_idx   = ctl.load_item ? STORE_AW'(read_address) : STORE_AW'(raddr_reg);

    assign sts.clear_last = (clr_idx_reg == STORE_AW'(ihex_pkg::STORE_WORDS - 1));
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.need_copy  = is_end && (ev == ihex_pkg::EV_ACCEPTED)
                          && (type_reg == 8'd0) && (len_reg[7:1] != 7'd0);
    assign sts.copy_last  = (copy_k_reg == (copy_n_reg - 7'd1));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 10'd0;
            nibble_reg    <= 4'd0;
            sum_reg       <= 8'd0;
            len_reg       <= 8'd0;
            addr_reg      <= 16'd0;
            type_reg      <= 8'd0;
            colon_ok_reg  <= 1'b1;
            end_miss_reg  <= 1'b0;
            err_reg       <= 1'b0;
            end_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_v_reg      <= 1'b0;
            clr_idx_reg   <= '0;
            copy_k_reg    <= 7'd0;
        end
        else
        begin
            count_reg    <= count_next;
            nibble_reg   <= nibble_next;
            sum_reg      <= sum_next;
            len_reg      <= len_next;
            addr_reg     <= addr_next;
            type_reg     <= type_next;
            colon_ok_reg <= colon_ok_next;
            end_miss_reg <= end_miss_next;
            err_reg      <= err_next;
            end_seen_reg <= end_seen_next;
            if (ctl.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            wr_v_reg <= ctl.copy_step;
            if (ctl.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + STORE_AW'(1);
            end
            if (ctl.exec)
            begin
                copy_k_reg <= 7'd0;
            end
            else if (ctl.copy_step)
            begin
                copy_k_reg <= copy_k_reg + 7'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg      <= cmd;
            char_reg     <= char_code;
            raddr_reg    <= read_address;
            in_range_reg <= ({7'd0, read_address} < 17'(ihex_pkg::STORE_WORDS));
        end
        if (ctl.exec)
        begin
            ev_out_reg      <= is_end ? ev : ihex_pkg::EV_NONE;
            verdict_out_reg <= verdict;
            word_out_reg    <= word_res;
            err_out_reg     <= err_next;
            copy_n_reg      <= len_reg[7:1];
            copy_base_reg   <= addr_reg[15:1];
        end
        if (ctl.copy_step)
        begin
            wr_addr_reg <= STORE_AW'(copy_sum);
            wr_ok_reg   <= ({1'b0, copy_k_reg} < 8'(ihex_pkg::COPY_PAIRS))
                        && (copy_sum < 17'(ihex_pkg::STORE_WORDS));
        end
    end

    // line byte banks, even and odd data bytes
    always_ff @(posedge clk)
    begin
        if (lb_we)
        begin
            if (data_idx[0])
            begin
                odd_mem[PAIR_AW'(data_idx[8:1])] <= byte_val;
            end
            else
            begin
                even_mem[PAIR_AW'(data_idx[8:1])] <= byte_val;
            end
        end
        lo_q <= even_mem[PAIR_AW'(copy_k_reg)];
        hi_q <= odd_mem[PAIR_AW'(copy_k_reg)];
    end

    // word store
    always_ff @(posedge clk)
    begin
        if (ctl.clear_step)
        begin
            word_mem[clr_idx_reg] <= ihex_pkg::ERASED_WORD;
        end
        else if (wr_v_reg && wr_ok_reg)
        begin
            word_mem[wr_addr_reg] <= {hi_q, lo_q};
        end
        word_q <= word_mem[rd_idx];
    end

    assign out_valid    = out_valid_reg;
    assign line_event   = ev_out_reg;
    assign file_verdict = verdict_out_reg;
    assign read_word    = word_out_reg;
    assign error_seen   = err_out_reg;

endmodule

[hw/rtl/intel_hex_record_loader.sv]
// Top level of the Intel HEX record loader: controller plus datapath.
// Depends on ihex_pkg, ihex_ctrl and ihex_dp.
//
// Takes Intel HEX text one character per transfer (cmd 0), ends a line on CR
// or LF, checks colon, length and checksum, and writes the data of valid type 0
// records as little-endian words into a 1024-word store at address/2; cmd 1
// reads a stored word and cmd 2 returns the file verdict. Every input transfer
// gives exactly one output transfer. After reset the store is swept to 0x3FFF
// one word per cycle with in_stall high. A character or a read is accepted, then
// executed once the output register can take its result; the result sits in that
// register, so the next item is accepted while it waits to be taken. A line end
// that accepts a type 0 record with N >= 2 data bytes then copies N/2 words (N/2
// rounded down) from the line byte banks into the store one word per cycle
// through its single write port, and a drain state follows, with in_stall high;
// with fewer than two data bytes nothing is copied and the copy states are skipped.
module intel_hex_record_loader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [9:0]  read_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  line_event,
    output logic [1:0]  file_verdict,
    output logic [15:0] read_word,
    output logic        error_seen
);

    ihex_pkg::ctl_cmd_t ctl;
    ihex_pkg::dp_sts_t  sts;

    // sequencing: clear sweep, execute, word copy
    ihex_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ctl      (ctl),
        .sts      (sts)
    );

    // parser, buffers, store and the output register
    ihex_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cmd          (cmd),
        .char_code    (char_code),
        .read_address (read_address),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .line_event   (line_event),
        .file_verdict (file_verdict),
        .read_word    (read_word),
        .error_seen   (error_seen)
    );

    // no new item may enter while words are still being copied
    a_copy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.copy_step |-> in_stall)
        else $error("item accepted during word copy");

    // an executed item always presents its result next cycle
    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> out_valid)
        else $error("executed item produced no result");

    // a valid verdict cannot coexist with a rejected line
    a_valid_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (file_verdict == ihex_pkg::VERDICT_VALID)) |-> !error_seen)
        else $error("valid verdict with error flag set");

    // the error flag never clears once reported
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_seen) |=> (!out_valid || error_seen))
        else $error("error flag cleared");

endmodule

[tb/ihex_result_checker.sv]
// Result checker for intel_hex_record_loader: tracks input and output transfers,
// predicts each result from its own copy of the loader state, and counts failures.
// Depends on ihex_pkg for widths, command, event and verdict codes.
module ihex_result_checker
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [9:0]  read_address,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  line_event,
    input  logic [1:0]  file_verdict,
    input  logic [15:0] read_word,
    input  logic        error_seen,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    localparam logic [87:0] END_TEXT    = ":00000001FF";

    typedef struct packed {
        logic [1:0]  ev;
        logic [1:0]  verdict;
        logic [15:0] word;
        logic        err;
    } loader_result_t;

    // shadow of the loader
    logic [15:0] word_image [STORE_WORDS];
    logic [7:0]  line_buf [LINE_BYTES];
    logic [9:0]  n_chars;
    logic [3:0]  hi_nib;
    logic [7:0]  csum;
    logic [7:0]  rec_len;
    logic [15:0] rec_addr;
    logic [7:0]  rec_type;
    logic        colon_ok;
    logic        end_miss;
    logic        bad_file;
    logic        end_seen;

    loader_result_t pending_results [$];
    loader_result_t want;
    loader_result_t predicted;
    int unsigned    fails = 0;

    assign fail_count  = fails;
    assign outstanding = pending_results.size();

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 8'd10);
        return 4'd0;
    endfunction

    task automatic report(input string msg);
        fails++;
        $error("%s", msg);
    endtask

    task automatic clear_line();
        n_chars  = '0;
        hi_nib   = '0;
        csum     = '0;
        rec_len  = '0;
        rec_addr = '0;
        rec_type = '0;
        colon_ok = 1'b1;
        end_miss = 1'b0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        int p;
        int b;
        logic [7:0] v;
        p = int'(n_chars);
        if (p >= int'(COUNT_MAX))
        begin
            end_miss = 1'b1;
            return;
        end
        if (p >= int'(END_LEN))
            end_miss = 1'b1;
        else if (c != END_TEXT[8*(10-p) +: 8])
            end_miss = 1'b1;

        if (p == 0)
        begin
            if (c != CH_COLON)
                colon_ok = 1'b0;
        end
        else if (p % 2 == 1)
        begin
            hi_nib = nibble_of(c);
        end
        else
        begin
            v = {hi_nib, nibble_of(c)};
            b = p / 2 - 1;
            csum += v;
            case (b)
                0:       rec_len = v;
                1:       rec_addr[15:8] = v;
                2:       rec_addr[7:0] = v;
                3:       rec_type = v;
                default:
                begin
                    if (b - 4 < LINE_BYTES)
                        line_buf[b-4] = v;
                end
            endcase
        end
        n_chars = 10'(p + 1);
    endtask

    // data pairs go in little-endian; pairs past the buffer or the store are lost
    task automatic commit_words();
        int k;
        int wa;
        for (k = 0; k < int'(rec_len) / 2; k++)
        begin
            wa = int'(rec_addr >> 1) + k;
            if (2 * k + 1 < LINE_BYTES && wa < STORE_WORDS)
                word_image[wa] = {line_buf[2*k+1], line_buf[2*k]};
        end
    endtask

    task automatic finish_line(output logic [1:0] ev);
        ev = EV_NONE;
        if (n_chars == 0)
            return;
        if (!bad_file)
        begin
            if (!end_miss && n_chars == END_LEN)
            begin
                end_seen = 1'b1;
                ev       = EV_END;
            end
            else if (colon_ok && int'(n_chars) == int'(END_LEN) + 2 * int'(rec_len) &&
                     csum == 8'd0)
            begin
                ev = EV_ACCEPTED;
                if (rec_type == 8'd0)
                    commit_words();
            end
            else
            begin
                ev       = EV_REJECTED;
                bad_file = 1'b1;
            end
        end
        clear_line();
    endtask

    task automatic predict_loader_result(input logic [1:0] c, input logic [7:0] ch,
                                         input logic [9:0] ra, output loader_result_t r);
        r = '0;
        case (c)
            CMD_CHAR:
            begin
                if (ch == CH_CR || ch == CH_LF)
                    finish_line(r.ev);
                else
                    absorb_char(ch);
            end
            CMD_READ:
            begin
                if (int'(ra) < STORE_WORDS)
                    r.word = word_image[ra];
            end
            CMD_VERDICT:
            begin
                finish_line(r.ev);
                r.verdict = (!bad_file && end_seen) ? VERDICT_VALID : VERDICT_INVALID;
            end
            default: ;
        endcase
        r.err = bad_file;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_WORDS; i++)
                word_image[i] = ERASED_WORD;
            clear_line();
            bad_file = 1'b0;
            end_seen = 1'b0;
            pending_results.delete();
        end
        else
        begin
            // results always trail their inputs, so retire before predicting
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report("result transfer with no result expected");
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (line_event !== want.ev)
                        report($sformatf("line_event: expected %0h, got %0h",
                                         want.ev, line_event));
                    if (file_verdict !== want.verdict)
                        report($sformatf("file_verdict: expected %0h, got %0h",
                                         want.verdict, file_verdict));
                    if (read_word !== want.word)
                        report($sformatf("read_word: expected %04h, got %04h",
                                         want.word, read_word));
                    if (error_seen !== want.err)
                        report($sformatf("error_seen: expected %0h, got %0h",
                                         want.err, error_seen));
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_loader_result(cmd, char_code, read_address, predicted);
                pending_results.push_back(predicted);
            end
        end
    end

endmodule

[tb/testbench.sv]
// Top of the intel_hex_record_loader testbench: clock, reset, HEX text stimulus,
// output stall pattern and verdict. Depends on ihex_pkg and ihex_result_checker.
module testbench;
    import ihex_pkg::*;

    // cmd 3 is not decoded by the loader; it must come back as an empty result
    localparam logic [1:0]  CMD_JUNK     = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 200;
    localparam int unsigned HOLD_AT      = 40;    // long output hold-off starts here
    localparam int unsigned FLAW_AT      = 130;   // first broken line of the file
    localparam int unsigned QUIET_AT     = 160;   // no idling on either side from here
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    // ways to spoil a record line
    typedef enum {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_COLON,
        FLAW_SHORT,
        FLAW_EXTRA
    } rec_flaw_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [9:0]  read_address;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  line_event;
    logic [1:0]  file_verdict;
    logic [15:0] read_word;
    logic        error_seen;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;
    bit          idle_on = 1'b0;   // random idle bursts allowed on both sides
    bit          hold_req = 1'b0;  // ask the receiver for one long hold-off

    intel_hex_record_loader uut (.*);

    ihex_result_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .char_code    (char_code),
        .read_address (read_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_event   (line_event),
        .file_verdict (file_verdict),
        .read_word    (read_word),
        .error_seen   (error_seen),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog. The budget covers the post-reset store sweep, the long hold-off,
    // worst-case idle bursts on both sides for every transfer, and word copies.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** intel_hex_record_loader: FAILED **");
            $finish;
        end
    end

    // Receiver side: random stall bursts while idling is on, plus one long
    // hold-off on request so the output register and the input side back up.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // One input transfer. Entered and left at a falling edge; valid stays high
    // between back-to-back items and only drops for an idle burst.
    task automatic send_item(input logic [1:0] c, input logic [7:0] ch,
                             input logic [9:0] ra);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        char_code    <= ch;
        read_address <= ra;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // unused fields carry random values so they toggle too
    task automatic send_char(input logic [7:0] ch);
        send_item(CMD_CHAR, ch, 10'($urandom));
    endtask

    task automatic send_read(input logic [9:0] ra);
        send_item(CMD_READ, 8'($urandom), ra);
    endtask

    task automatic send_verdict();
        send_item(CMD_VERDICT, 8'($urandom), 10'($urandom));
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // CR, LF or CR LF; the LF after a CR is an empty line
    task automatic send_eol();
        case ($urandom_range(0, 2))
            0: send_char(CH_CR);
            1: send_char(CH_LF);
            default:
            begin
                send_char(CH_CR);
                send_char(CH_LF);
            end
        endcase
    endtask

    // any character but a line end
    function automatic logic [7:0] stray_char();
        logic [7:0] ch;
        ch = 8'($urandom);
        while (ch == CH_CR || ch == CH_LF)
            ch = 8'($urandom);
        return ch;
    endfunction

    // Hex digit in random case. A zero nibble may be sent as any non-hex
    // character (odd_rate out of 16), which the loader reads as zero.
    function automatic logic [7:0] digit_char(input logic [3:0] v,
                                              input int unsigned odd_rate);
        logic [7:0] ch;
        if (v == 4'd0 && $urandom_range(0, 15) < odd_rate)
        begin
            ch = stray_char();
            while ((ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "F") ||
                   (ch >= "a" && ch <= "f"))
                ch = stray_char();
        end
        else if (v < 4'd10)
            ch = 8'h30 + 8'(v);
        else if ($urandom_range(0, 1) == 0)
            ch = "A" + 8'(v - 4'd10);
        else
            ch = "a" + 8'(v - 4'd10);
        return ch;
    endfunction

    // Full record line with random data, correct checksum unless spoiled.
    task automatic send_record(input int unsigned len, input logic [15:0] addr,
                               input logic [7:0] rtype, input rec_flaw_t flaw,
                               input int unsigned odd_rate);
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] lead;
        body = {8'(len), addr[15:8], addr[7:0], rtype};
        repeat (len) body.push_back(8'($urandom));
        sum = 8'd0;
        foreach (body[i])
            sum += body[i];
        body.push_back(8'd0 - sum);
        case (flaw)
            FLAW_CHECKSUM: body[body.size()-1] += 8'($urandom_range(1, 255));
            FLAW_EXTRA:    body.push_back(8'h00);  // length field now too small
            default: ;
        endcase
        lead = CH_COLON;
        if (flaw == FLAW_COLON)
            while (lead == CH_COLON)
                lead = stray_char();
        send_char(lead);
        foreach (body[i])
        begin
            send_char(digit_char(body[i][7:4], odd_rate));
            if (!(flaw == FLAW_SHORT && i == body.size() - 1))
                send_char(digit_char(body[i][3:0], odd_rate));
        end
        send_eol();
    endtask

    initial
    begin
        int unsigned start_count;
        int unsigned pick;
        int unsigned sel;
        int unsigned len;
        logic [15:0] addr;
        logic [7:0]  rtype;
        rec_flaw_t   flaw;
        bit          hold_done;
        bit          flaw_done;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_CHAR;
        char_code    = 8'd0;
        read_address = 10'd0;
        hold_done    = 1'b0;
        flaw_done    = 1'b0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_on = 1'b1;

        // ---- directed part ----
        // verdict before any end record: invalid
        send_verdict();
        // both ends of the store still hold the erased pattern
        send_read(10'd0);
        send_read(10'd1023);
        send_item(CMD_JUNK, 8'hFF, 10'h3FF);
        // empty lines are skipped
        send_char(CH_CR);
        send_char(CH_LF);
        send_record(2, 16'h0000, 8'h00, FLAW_NONE, 0);
        send_read(10'd0);
        // odd data length, odd byte address, zero nibbles as non-hex characters
        send_record(3, 16'h0003, 8'h00, FLAW_NONE, 16);
        send_read(10'd1);
        send_read(10'd2);
        // extended address record: accepted but stores nothing
        send_record(2, 16'h0010, 8'h04, FLAW_NONE, 0);
        send_read(10'd8);
        send_record(0, 16'h0020, 8'h00, FLAW_NONE, 0);
        // straddles the top of the store: second word is dropped
        send_record(4, 16'h07FE, 8'h00, FLAW_NONE, 0);
        send_read(10'd1023);
        send_record(2, 16'hFFFF, 8'hFF, FLAW_NONE, 0);
        // longest record
        send_record(255, 16'h0100, 8'h00, FLAW_NONE, 2);
        send_read(10'd128);
        send_read(10'd254);
        // lower-case end text is an ordinary type 1 record
        send_chars(":00000001ff");
        send_eol();
        // end record left open: the verdict closes it and reports both
        send_chars(":00000001FF");
        send_verdict();
        send_verdict();

        // ---- random part ----
        // Mostly well-formed records so the file stays valid until the flaw
        // point; after the first bad line everything else must be ignored.
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            idle_on = (items_sent - start_count < QUIET_AT) &&
                      (((items_sent - start_count) / 70) % 3 != 2);
            if (!hold_done && items_sent - start_count >= HOLD_AT)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!flaw_done && items_sent - start_count >= FLAW_AT)
            begin
                flaw_done = 1'b1;
                send_record($urandom_range(0, 8), 16'($urandom_range(0, 127)),
                            8'h00, rec_flaw_t'($urandom_range(1, 4)), 2);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    len = ($urandom_range(0, 49) == 0) ? $urandom_range(64, 255)
                                                       : $urandom_range(0, 16);
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        addr = 16'($urandom);
                    else if (sel == 1)
                        addr = 16'h07C0 + 16'($urandom_range(0, 63));
                    else
                        addr = 16'($urandom_range(0, 127));
                    rtype = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 5)) : 8'h00;
                    flaw = (flaw_done && $urandom_range(0, 2) == 0)
                           ? rec_flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
                    send_record(len, addr, rtype, flaw, 2);
                end
                else if (pick < 78)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        send_read(10'($urandom));
                    else if (sel == 1)
                        send_read(10'($urandom_range(992, 1023)));
                    else
                        send_read(10'($urandom_range(0, 63)));
                end
                else if (pick < 83)
                begin
                    send_chars(":00000001FF");
                    send_eol();
                end
                else if (pick < 88)
                    send_verdict();
                else if (pick < 91)
                    send_item(CMD_JUNK, 8'($urandom), 10'($urandom));
                else
                    send_eol();
            end
        end
        send_verdict();
        in_valid <= 1'b0;

        // drain, then give stray transfers a chance to show up
        wait (outstanding == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("** intel_hex_record_loader: PASSED **");
        else
            $display("** intel_hex_record_loader: FAILED **");
        $finish;
    end

endmodule
